/* src/oversampled_uart_byte_receiver_macros.svh */
// assertion macros used by the frame sequencer module
`ifndef OVERSAMPLED_UART_BYTE_RECEIVER_MACROS_SVH
`define OVERSAMPLED_UART_BYTE_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define OURX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OURX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OURX_ASSERT_NOW(lbl, ante, cons, msg)
`define OURX_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/ourx_pkg.sv */
// types and constants of the oversampled uart byte receiver
`timescale 1ns / 1ps

package ourx_pkg;

	// ring depth is a power of two, so head and fill wrap naturally
	localparam int RING_AW    = 9;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int DATA_BITS  = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_CONFIRM_DELAY      = 2'd0;
	localparam logic [1:0] CFG_FIRST_SAMPLE_DELAY = 2'd1;
	localparam logic [1:0] CFG_BIT_PERIOD         = 2'd2;

	// reset values of the configuration registers
	localparam logic [3:0] CONFIRM_DELAY_RST      = 4'd4;
	localparam logic [5:0] FIRST_SAMPLE_DELAY_RST = 6'd14;
	localparam logic [4:0] BIT_PERIOD_RST         = 5'd10;

	// result status codes
	localparam logic RX_STATUS_OK      = 1'b0;
	localparam logic RX_STATUS_FRAMING = 1'b1;

	typedef struct packed {
		logic [3:0] confirm_delay;
		logic [5:0] first_sample_delay;
		logic [4:0] bit_period;
	} cfg_t;

	typedef struct packed {
		logic               line_level;
		logic [RING_AW-1:0] consumer_index;
	} tick_t;

	typedef struct packed {
		logic               rx_status;
		logic [7:0]         rx_byte;
		logic [RING_AW-1:0] ring_write_index;
		logic [RING_AW-1:0] fill_count;
		logic [RING_AW-1:0] peak_fill;
	} result_t;

endpackage

/* src/ourx_cfg_regs.sv */
// configuration registers of the receiver
`timescale 1ns / 1ps

module ourx_cfg_regs import ourx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output logic       cfg_ready,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_delay      <= CONFIRM_DELAY_RST;
			cfg_q.first_sample_delay <= FIRST_SAMPLE_DELAY_RST;
			cfg_q.bit_period         <= BIT_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CONFIRM_DELAY:      cfg_q.confirm_delay      <= cfg_data[3:0];
				CFG_FIRST_SAMPLE_DELAY: cfg_q.first_sample_delay <= cfg_data;
				CFG_BIT_PERIOD:         cfg_q.bit_period         <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

endmodule

/* src/ourx_frame.sv */
// frame sequencer and ring head bookkeeping, one tick per step
`timescale 1ns / 1ps
`include "oversampled_uart_byte_receiver_macros.svh"

module ourx_frame import ourx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  tick_t   tick_s1,
	output logic    res_valid,
	output result_t res
);

	localparam logic [1:0] STAGE_IDLE    = 2'd0;
	localparam logic [1:0] STAGE_CONFIRM = 2'd1;
	localparam logic [1:0] STAGE_DATA    = 2'd2;
	localparam logic [1:0] STAGE_STOP    = 2'd3;

	logic [1:0]         stage_q, stage_d;
	logic [8:0]         tick_q, tick_d;
	logic [8:0]         next_q, next_d;
	logic [3:0]         slot_q, slot_d;
	logic [7:0]         shift_q, shift_d;
	logic [RING_AW-1:0] head_q, head_d;
	logic [RING_AW-1:0] peak_q, peak_d;

	logic [8:0]         tick_inc;
	logic [3:0]         slot_inc;
	logic [RING_AW-1:0] head_inc;
	logic [RING_AW-1:0] fill;

	assign tick_inc = tick_q + 9'd1;
	assign slot_inc = slot_q + 4'd1;
	assign head_inc = head_q + RING_AW'(1);
	assign fill     = head_inc - tick_s1.consumer_index;

	always_comb begin
		stage_d   = stage_q;
		tick_d    = tick_q;
		next_d    = next_q;
		slot_d    = slot_q;
		shift_d   = shift_q;
		head_d    = head_q;
		peak_d    = peak_q;
		res_valid = 1'b0;
		res       = '0;
		if (step) begin
			if (stage_q == STAGE_IDLE) begin
				// a low level in idle opens a frame
				if (!tick_s1.line_level) begin
					stage_d = STAGE_CONFIRM;
					tick_d  = 9'd1;
					next_d  = {5'd0, cfg.confirm_delay};
					slot_d  = '0;
				end
			end else begin
				tick_d = tick_inc;
				if (tick_inc >= next_q) begin
					unique case (stage_q)
						STAGE_CONFIRM: begin
							if (tick_s1.line_level) begin
								// glitch, drop the frame quietly
								stage_d = STAGE_IDLE;
								tick_d  = '0;
								next_d  = '0;
								slot_d  = '0;
							end else begin
								stage_d = STAGE_DATA;
								next_d  = {3'd0, cfg.first_sample_delay};
								shift_d = '0;
							end
						end
						STAGE_DATA: begin
							if (tick_s1.line_level && !slot_q[3]) begin
								shift_d[slot_q[2:0]] = 1'b1;
							end
							slot_d = slot_inc;
							next_d = next_q + {4'd0, cfg.bit_period};
							if (slot_inc >= 4'(DATA_BITS)) begin
								stage_d = STAGE_STOP;
							end
						end
						STAGE_STOP: begin
							res_valid = 1'b1;
							if (!tick_s1.line_level) begin
								res.rx_status = RX_STATUS_FRAMING;
								res.peak_fill = peak_q;
							end else begin
								head_d = head_inc;
								if (fill >= peak_q) begin
									peak_d = fill;
								end
								res.rx_status        = RX_STATUS_OK;
								res.rx_byte          = shift_q;
								res.ring_write_index = head_q;
								res.fill_count       = fill;
								res.peak_fill        = (fill >= peak_q) ? fill : peak_q;
							end
							stage_d = STAGE_IDLE;
							tick_d  = '0;
							next_d  = '0;
							slot_d  = '0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STAGE_IDLE;
			tick_q  <= '0;
			next_q  <= '0;
			slot_q  <= '0;
			shift_q <= '0;
			head_q  <= '0;
			peak_q  <= '0;
		end else begin
			stage_q <= stage_d;
			tick_q  <= tick_d;
			next_q  <= next_d;
			slot_q  <= slot_d;
			shift_q <= shift_d;
			head_q  <= head_d;
			peak_q  <= peak_d;
		end
	end

	`OURX_ASSERT_NOW(a_idle_clear, stage_q == STAGE_IDLE, tick_q == '0 && slot_q == '0, "idle with live counters")
	`OURX_ASSERT_NOW(a_result_at_stop, res_valid, step && stage_q == STAGE_STOP, "result outside stop bit")
	`OURX_ASSERT_NOW(a_stop_slot, stage_q == STAGE_STOP, slot_q == 4'(DATA_BITS), "stop without all data bits")
	`OURX_ASSERT_NEXT(a_peak_grows, 1'b1, peak_q >= $past(peak_q), "peak fill went down")

endmodule

/* src/oversampled_uart_byte_receiver.sv */
// top level of the oversampled 8N1 uart byte receiver
`timescale 1ns / 1ps

// Oversampled 8N1 uart receiver. Each tick item carries one line sample and
// the consumer's ring read index; a low level in idle starts a frame, the
// start bit is rechecked confirm_delay ticks in, eight data bits are taken
// lsb first from first_sample_delay on, one per bit_period, and the stop bit
// one period after the last. A good stop bit gives a result item with the
// byte, its ring slot, the fill count and the peak fill; a low stop bit gives
// a framing error item. One tick item is taken every clock cycle while
// tick_stall is low; it is registered, stepped through the frame sequencer
// once the output register can advance, and its result, if any, lands in
// the output register. Stall on the result side backs up into the tick side
// only once the output register holds an item that is not taken. The user
// must write configuration only while no frame is in flight (not enforced).

module oversampled_uart_byte_receiver import ourx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// tick items
	input  logic       tick_valid,
	output logic       tick_stall,
	input  tick_t      tick,
	// result items
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;
	logic    step;
	logic    res_valid;
	result_t res;

	// output register free or draining this cycle
	assign advance    = !out_valid_q || !result_stall;
	assign step       = valid_s1 && advance;
	// input register holds only while its item cannot move on
	assign tick_stall = valid_s1 && !advance;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	ourx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	ourx_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.tick_s1   (tick_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_valid && !tick_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

endmodule

/* test/tb_top.sv */
// self-checking testbench of the oversampled uart byte receiver
`timescale 1ns / 1ps

module tb_top;
	import ourx_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int IDLE_PERCENT   = 17;
	// the tick path is two registers deep, so SETTLE_CYCLES covers any leftover work
	localparam int SETTLE_CYCLES  = 4;

	// where the receiver stands inside a frame
	typedef enum logic [1:0] {HUNT, START_BIT, SHIFT_IN, STOP_BIT} frame_phase_e;
	// shapes of generated frames
	typedef enum {CLEAN_FRAME, STOP_LOW, START_GLITCH} frame_kind_e;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       tick_valid   = 1'b0;
	logic       tick_stall;
	tick_t      tick         = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index    = CFG_CONFIRM_DELAY;
	logic [5:0] cfg_data     = '0;

	oversampled_uart_byte_receiver DUT (.*);

	// line samples waiting to be driven, results owed by the receiver
	tick_t   line_ticks[$];
	result_t frames_due[$];

	// shadow receiver: configuration and frame state as of the last accepted tick
	cfg_t               rx_cfg;
	frame_phase_e       frame_phase;
	logic [8:0]         frame_ticks;
	logic [8:0]         event_at;
	logic [3:0]         bits_taken;
	logic [7:0]         shift_reg;
	logic [RING_AW-1:0] ring_head;
	logic [RING_AW-1:0] fill_peak;

	int unsigned ticks_queued    = 0;
	int unsigned ticks_taken     = 0;
	int unsigned bytes_checked   = 0;
	int unsigned framing_checked = 0;
	int unsigned settings_used   = 1;
	int unsigned quiet_cycles    = 0;
	int unsigned errors          = 0;
	// no idling on either side while set
	logic        calm            = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// back to hunting for a start edge
	task automatic close_frame();
		frame_phase = HUNT;
		frame_ticks = '0;
		event_at    = '0;
		bits_taken  = '0;
	endtask

	// advance the shadow receiver by one line sample, queue the result it owes
	task automatic receive_tick(input tick_t item);
		result_t outcome;
		outcome = '0;
		if (frame_phase == HUNT) begin
			// a low level starts a frame, tick count starts at one
			if (!item.line_level) begin
				frame_phase = START_BIT;
				frame_ticks = 9'd1;
				event_at    = 9'(rx_cfg.confirm_delay);
				bits_taken  = '0;
			end
			return;
		end
		frame_ticks = frame_ticks + 9'd1;
		if (frame_ticks < event_at)
			return;
		case (frame_phase)
			START_BIT: begin
				// start bit gone high at the recheck: drop the frame silently
				if (item.line_level) begin
					close_frame();
				end else begin
					frame_phase = SHIFT_IN;
					event_at    = 9'(rx_cfg.first_sample_delay);
					shift_reg   = '0;
				end
			end
			SHIFT_IN: begin
				// lsb first, next sample one period after the scheduled one
				if (item.line_level && bits_taken < 4'd8)
					shift_reg[bits_taken[2:0]] = 1'b1;
				bits_taken = bits_taken + 4'd1;
				event_at   = event_at + 9'(rx_cfg.bit_period);
				if (bits_taken >= DATA_BITS)
					frame_phase = STOP_BIT;
			end
			default: begin
				if (!item.line_level) begin
					// framing error: no byte, no slot, head stays put
					outcome.rx_status = RX_STATUS_FRAMING;
				end else begin
					outcome.rx_status        = RX_STATUS_OK;
					outcome.rx_byte          = shift_reg;
					outcome.ring_write_index = ring_head;
					ring_head                = ring_head + 1'b1;
					outcome.fill_count       = ring_head - item.consumer_index;
					if (outcome.fill_count >= fill_peak)
						fill_peak = outcome.fill_count;
				end
				outcome.peak_fill = fill_peak;
				frames_due.push_back(outcome);
				close_frame();
			end
		endcase
	endtask

	task automatic push_tick(input logic level, input logic [RING_AW-1:0] consumer);
		tick_t item;
		item.line_level     = level;
		item.consumer_index = consumer;
		line_ticks.push_back(item);
		ticks_queued++;
	endtask

	task automatic queue_idle(input int unsigned count);
		repeat (count) push_tick(1'b1, RING_AW'($urandom_range(0, RING_DEPTH - 1)));
	endtask

	// one frame laid out on the tick grid of the current settings; with jitter
	// the line toggles at random on every tick that is not a sample point
	task automatic queue_frame(input logic [7:0] data, input frame_kind_e kind,
			input int stop_consumer, input bit jitter);
		int unsigned        mark[10];
		logic               level[10];
		int unsigned        last;
		int unsigned        t;
		logic [RING_AW-1:0] consumer;
		// sample points: start recheck, eight data bits, stop bit
		mark[0] = (rx_cfg.confirm_delay < 2) ? 2 : rx_cfg.confirm_delay;
		mark[1] = (rx_cfg.first_sample_delay > mark[0]) ? rx_cfg.first_sample_delay
			: mark[0] + 1;
		for (int k = 2; k < 10; k++) begin
			mark[k] = rx_cfg.first_sample_delay + (k - 1) * rx_cfg.bit_period;
			if (mark[k] <= mark[k - 1])
				mark[k] = mark[k - 1] + 1;
		end
		level[0] = (kind == START_GLITCH);
		for (int k = 1; k < 9; k++)
			level[k] = data[k - 1];
		level[9] = (kind != STOP_LOW);
		last = (kind == START_GLITCH) ? mark[0] : mark[9];
		push_tick(1'b0, RING_AW'($urandom_range(0, RING_DEPTH - 1)));
		t = 2;
		for (int k = 0; k < 10 && t <= last; k++) begin
			while (t <= mark[k]) begin
				consumer = RING_AW'($urandom_range(0, RING_DEPTH - 1));
				if (t == last && stop_consumer >= 0)
					consumer = RING_AW'(stop_consumer);
				push_tick((t == mark[k] || !jitter) ? level[k] : 1'($urandom_range(0, 1)),
					consumer);
				t++;
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (ticks_taken != ticks_queued || frames_due.size() != 0);
	endtask

	// all ticks taken, all results back, and the receiver hunting again
	task automatic settle();
		wait_drained();
		while (frame_phase != HUNT) begin
			push_tick(1'b1, RING_AW'($urandom_range(0, RING_DEPTH - 1)));
			wait_drained();
		end
	endtask

	// mostly well-formed frames with random content, some broken ones and noise
	task automatic queue_mixed_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned roll;
		stop_at = ticks_queued + count;
		while (ticks_queued < stop_at) begin
			roll = $urandom_range(0, 99);
			if (roll < 62) begin
				queue_frame(8'($urandom_range(0, 255)), CLEAN_FRAME, -1, 1'($urandom_range(0, 1)));
			end else if (roll < 74) begin
				queue_frame(8'($urandom_range(0, 255)), STOP_LOW, -1, 1'($urandom_range(0, 1)));
			end else if (roll < 84) begin
				queue_frame(8'($urandom_range(0, 255)), START_GLITCH, -1, 1'($urandom_range(0, 1)));
			end else if (roll < 93) begin
				queue_idle($urandom_range(1, 5));
			end else begin
				// random line, then let whatever frame it opened run out
				repeat ($urandom_range(4, 24))
					push_tick(1'($urandom_range(0, 1)), RING_AW'($urandom_range(0, RING_DEPTH - 1)));
				settle();
			end
		end
	endtask

	// called on a rising edge; valid stays up across back-to-back writes
	task automatic write_register(input logic [1:0] index, input logic [5:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (index)
			CFG_CONFIRM_DELAY:      rx_cfg.confirm_delay      = data[3:0];
			CFG_FIRST_SAMPLE_DELAY: rx_cfg.first_sample_delay = data;
			CFG_BIT_PERIOD:         rx_cfg.bit_period         = data[4:0];
			default: ;
		endcase
	endtask

	task automatic write_config(input logic [3:0] confirm, input logic [5:0] first,
			input logic [4:0] period);
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(CFG_CONFIRM_DELAY, 6'(confirm));
		write_register(CFG_FIRST_SAMPLE_DELAY, first);
		write_register(CFG_BIT_PERIOD, 6'(period));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// tick driver: next item once the current one is taken, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick       <= '0;
		end else if (!tick_valid || !tick_stall) begin
			if (line_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				tick_valid <= 1'b1;
				tick       <= line_ticks.pop_front();
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= !calm && $urandom_range(0, 99) < IDLE_PERCENT;
	end

	// monitor: results are checked before the tick of this edge is predicted,
	// since a result never belongs to the tick taken at the same edge
	always @(posedge clk) begin : line_monitor
		result_t due;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (frames_due.size() == 0) begin
					errors++;
					$display("%0t: result with none due, expected nothing, actual %h", $time, result);
				end else begin
					due = frames_due.pop_front();
					check_field("rx_status", due.rx_status, result.rx_status);
					check_field("rx_byte", due.rx_byte, result.rx_byte);
					check_field("ring_write_index", due.ring_write_index, result.ring_write_index);
					check_field("fill_count", due.fill_count, result.fill_count);
					check_field("peak_fill", due.peak_fill, result.peak_fill);
					if (due.rx_status == RX_STATUS_FRAMING)
						framing_checked++;
					else
						bytes_checked++;
				end
			end
			if (tick_valid && !tick_stall) begin
				receive_tick(tick);
				ticks_taken++;
			end
			// watchdog on any handshake
			if ((tick_valid && !tick_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results still due",
					$time, quiet_cycles, frames_due.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		rx_cfg = {CONFIRM_DELAY_RST, FIRST_SAMPLE_DELAY_RST, BIT_PERIOD_RST};
		close_frame();
		shift_reg = '0;
		ring_head = '0;
		fill_peak = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: consumer index extremes while idle, a byte landing
		// with zero fill, and a framing error
		push_tick(1'b1, '0);
		push_tick(1'b1, '1);
		queue_frame(8'hA5, CLEAN_FRAME, int'(ring_head) + 1, 1'b0);
		queue_frame(8'h3C, STOP_LOW, -1, 1'b1);
		queue_idle(2);

		// short frames: byte extremes, a start glitch, a framing error after
		// all ones (byte must read zero), line jitter between sample points
		write_config(4'd2, 6'd4, 5'd2);
		queue_frame(8'h00, CLEAN_FRAME, -1, 1'b0);
		queue_frame(8'hFF, CLEAN_FRAME, -1, 1'b0);
		queue_frame(8'hFF, START_GLITCH, -1, 1'b0);
		queue_frame(8'hFF, STOP_LOW, -1, 1'b0);
		queue_frame(8'h80, CLEAN_FRAME, -1, 1'b1);
		queue_idle(1);
		queue_frame(8'h01, CLEAN_FRAME, 0, 1'b1);

		// smallest legal delays
		write_config(4'd1, 6'd2, 5'd1);
		queue_mixed_traffic(110);

		// all zero: recheck on the next tick, a sample on every tick
		write_config(4'd0, 6'd0, 5'd0);
		queue_mixed_traffic(110);

		// largest delays, frames over three hundred ticks long
		write_config(4'd15, 6'd63, 5'd31);
		queue_frame(8'h96, CLEAN_FRAME, -1, 1'b1);
		queue_frame(8'h00, START_GLITCH, -1, 1'b0);

		// first sample not past the recheck tick
		write_config(4'd9, 6'd3, 5'd2);
		queue_mixed_traffic(110);

		// no idling on either side for a whole phase
		write_config(4'd3, 6'd8, 5'd3);
		calm <= 1'b1;
		queue_mixed_traffic(110);
		settle();
		calm <= 1'b0;

		write_config(4'($urandom_range(1, 7)), 6'($urandom_range(2, 16)),
			5'($urandom_range(1, 4)));
		queue_mixed_traffic(110);

		// back to reset values; the consumer one ahead of the new head gives
		// the largest fill and pins the peak there
		write_config(CONFIRM_DELAY_RST, FIRST_SAMPLE_DELAY_RST, BIT_PERIOD_RST);
		queue_frame(8'h5A, CLEAN_FRAME, (int'(ring_head) + 2) % RING_DEPTH, 1'b1);
		queue_frame(8'($urandom_range(0, 255)), CLEAN_FRAME, -1, 1'b1);

		settle();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		$display("run covered %0d line ticks under %0d register settings",
			ticks_taken, settings_used);
		$display("checked %0d received bytes and %0d framing errors",
			bytes_checked, framing_checked);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/ourx_pkg.sv
src/ourx_cfg_regs.sv
src/ourx_frame.sv
src/oversampled_uart_byte_receiver.sv
test/tb_top.sv
